// ===== sv/euler_conserved_primitive_convert_core_assert.svh =====
// Assertion macros shared by the converter checker.
`ifndef EULER_CONSERVED_PRIMITIVE_CONVERT_CORE_ASSERT_SVH
`define EULER_CONSERVED_PRIMITIVE_CONVERT_CORE_ASSERT_SVH

// Same-cycle implication under the synchronous reset.
`define ECPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the synchronous reset.
`define ECPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ecpc_pkg.sv =====
// Shared types, codes and arithmetic helpers for the Euler cell converter.
`timescale 1ns / 1ps
package ecpc_pkg;

    localparam int W      = 32;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 1;
    localparam int DIV_W  = 65;
    localparam int DEN_W  = 32;

    localparam logic ACT_P2C = 1'b0;
    localparam logic ACT_C2P = 1'b1;

    localparam logic [1:0] FAULT_OK      = 2'd0;
    localparam logic [1:0] FAULT_DENSITY = 2'd1;
    localparam logic [1:0] FAULT_SAT     = 2'd2;

    localparam logic [IDX_W-1:0] CFG_GM1  = 1'b0;
    localparam logic [IDX_W-1:0] CFG_IGM1 = 1'b1;

    localparam logic [CFG_W-1:0] GM1_RST  = 31'd26214;
    localparam logic [CFG_W-1:0] IGM1_RST = 31'd163840;

    typedef struct packed {
        logic [W-1:0] val;
        logic         sat;
    } t_sat;

    // Clamp a signed 64-bit value to signed 32 bits and flag the clamp.
    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 64'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

    // Drop 16 fraction bits, rounding half toward plus infinity.
    function automatic logic signed [63:0] round16(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd32768;
        return t >>> 16;
    endfunction

endpackage

// ===== sv/ecpc_in_if.sv =====
// Input channel carrying one fluid cell per beat.
`timescale 1ns / 1ps
interface ecpc_in_if import ecpc_pkg::*; ();
    logic         valid;
    logic         ready;
    logic         action;
    logic [W-1:0] in_density;
    logic [W-1:0] in_x;
    logic [W-1:0] in_y;
    logic [W-1:0] in_z;
    logic [W-1:0] in_energy_or_pressure;

    modport source (output valid, action, in_density, in_x, in_y, in_z,
                    in_energy_or_pressure, input ready);
    modport sink   (input valid, action, in_density, in_x, in_y, in_z,
                    in_energy_or_pressure, output ready);
endinterface

// ===== sv/ecpc_out_if.sv =====
// Output channel carrying one converted cell per beat.
`timescale 1ns / 1ps
interface ecpc_out_if import ecpc_pkg::*; ();
    logic         valid;
    logic         ready;
    logic [W-1:0] out_density;
    logic [W-1:0] out_x;
    logic [W-1:0] out_y;
    logic [W-1:0] out_z;
    logic [W-1:0] out_energy_or_pressure;
    logic [1:0]   fault;

    modport source (output valid, out_density, out_x, out_y, out_z,
                    out_energy_or_pressure, fault, input ready);
    modport sink   (input valid, out_density, out_x, out_y, out_z,
                    out_energy_or_pressure, fault, output ready);
endinterface

// ===== sv/ecpc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module ecpc_div_pipe #(
    parameter int N = 65,
    parameter int D = 32
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [N-1:0] i_num,
    input  logic [D-1:0] i_den,
    output logic [N-1:0] o_quo,
    output logic         o_rem_nz
);

    // Each stage shifts one dividend bit out and one quotient bit in.
    logic [N-1:0] r_nq  [N];
    logic [D-1:0] r_rem [N];
    logic [D-1:0] r_den [N-1];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [N-1:0] nq_in;
        logic [D-1:0] rem_in;
        logic [D-1:0] den_in;
        logic [D:0]   rem_sh;
        logic         ge;
        logic [D-1:0] n_rem;
        logic [N-1:0] n_nq;

        if (s == 0) begin : g_first
            assign nq_in  = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign nq_in  = r_nq[s-1];
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
        end

        // Trial subtraction of the divisor from the shifted remainder.
        assign rem_sh = {rem_in, nq_in[N-1]};
        assign ge     = rem_sh >= {1'b0, den_in};
        assign n_rem  = ge ? D'(rem_sh - {1'b0, den_in}) : rem_sh[D-1:0];
        assign n_nq   = {nq_in[N-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[s]  <= n_nq;
                r_rem[s] <= n_rem;
            end
        end

        if (s < N - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s] <= den_in;
                end
            end
        end
    end

    assign o_quo    = r_nq[N-1];
    assign o_rem_nz = |r_rem[N-1];

endmodule

// ===== sv/euler_conserved_primitive_convert_core.sv =====
// Top level: ideal-gas Euler cell conversion between conserved and primitive form.
// One cell per cycle while the output is not stalled; the 65-stage divider pipeline sets the depth.
// The whole pipeline advances together when the output register is free or taken.
// Reset (synchronous, active low) clears all valid bits and loads the default
// gamma registers; there is no clearing pass and input is taken right after reset.
`timescale 1ns / 1ps
module euler_conserved_primitive_convert_core import ecpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    ecpc_in_if.sink          i_in,
    ecpc_out_if.source       o_out
);

    typedef struct packed {
        logic             act;
        logic             bad;
        logic [W-1:0]     rho;
        logic [W-1:0]     e;
        logic [2:0][W-1:0] mom;
        logic             sat0;
        logic [63:0]      ie;
        logic [63:0]      usq;
        logic [62:0]      pa;
        logic [62:0]      pb;
        logic [W-1:0]     e0;
        logic [2:0]       vneg;
    } t_car;

    typedef struct packed {
        logic              act;
        logic              bad;
        logic [W-1:0]      rho;
        logic [2:0][W-1:0] mom;
        logic [W-1:0]      e0;
        logic              sat0;
        logic [2:0][W-1:0] vel;
        logic              vsat;
    } t_post;

    typedef struct packed {
        logic [W-1:0] density;
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] z;
        logic [W-1:0] eop;
        logic [1:0]   fault;
    } t_res;

    // Configuration registers.
    logic [CFG_W-1:0] r_gm1;
    logic [CFG_W-1:0] r_igm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm1  <= GM1_RST;
            r_igm1 <= IGM1_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GM1:  r_gm1  <= i_cfg_data;
                CFG_IGM1: r_igm1 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Global stage enable: everything moves when the output slot frees up.
    logic en;
    logic r_out_vld;
    t_res r_out;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // Stage 1: all first-level products.
    logic signed [W-1:0]  s_rho;
    logic signed [W-1:0]  s_e;
    logic signed [W-1:0]  s_v   [3];
    logic signed [63:0]   n1_rv [3];
    logic [63:0]          n1_sq [3];
    logic signed [63:0]   n1_ei;

    logic                 r1_vld;
    logic                 r1_act;
    logic signed [W-1:0]  r1_rho;
    logic signed [W-1:0]  r1_e;
    logic signed [W-1:0]  r1_v  [3];
    logic signed [63:0]   r1_rv [3];
    logic [63:0]          r1_sq [3];
    logic signed [63:0]   r1_ei;

    assign s_rho  = i_in.in_density;
    assign s_e    = i_in.in_energy_or_pressure;
    assign s_v[0] = i_in.in_x;
    assign s_v[1] = i_in.in_y;
    assign s_v[2] = i_in.in_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_rv[i] = 64'(s_rho) * 64'(s_v[i]);
            n1_sq[i] = 64'(s_v[i]) * 64'(s_v[i]);
        end
        n1_ei = 64'(s_e) * 64'($signed({1'b0, r_igm1}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_act <= i_in.action;
            r1_rho <= s_rho;
            r1_e   <= s_e;
            r1_ei  <= n1_ei;
            for (int i = 0; i < 3; i++) begin
                r1_v[i]  <= s_v[i];
                r1_rv[i] <= n1_rv[i];
                r1_sq[i] <= n1_sq[i];
            end
        end
    end

    // Stage 2: rounding of momentum and internal energy, divider operands.
    t_car                n_car0;
    t_sat                s_mom [3];
    logic signed [63:0]  c_vnum [3];
    logic [63:0]         c_vmag [3];
    logic [DIV_W-1:0]    n2_vnum [3];
    logic [DIV_W-1:0]    n2_knum;
    logic [DEN_W-1:0]    n2_den;
    logic [63:0]         c_usq;

    logic [DIV_W-1:0]    r2_vnum [3];
    logic [DIV_W-1:0]    r2_knum;
    logic [DEN_W-1:0]    r2_den;

    always_comb begin
        c_usq  = r1_sq[0] + r1_sq[1] + r1_sq[2];
        n_car0 = '0;
        n_car0.act  = r1_act;
        n_car0.bad  = r1_rho <= 0;
        n_car0.rho  = r1_rho;
        n_car0.e    = r1_e;
        n_car0.ie   = round16(r1_ei);
        n_car0.usq  = c_usq;
        n_car0.sat0 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            s_mom[i]       = sat32(round16(r1_rv[i]));
            n_car0.mom[i]  = s_mom[i].val;
            n_car0.sat0    = n_car0.sat0 | s_mom[i].sat;
            c_vnum[i]      = (64'(r1_v[i]) <<< 17) + 64'(r1_rho);
            n_car0.vneg[i] = c_vnum[i][63];
            c_vmag[i]      = c_vnum[i][63] ? 64'(-c_vnum[i]) : 64'(c_vnum[i]);
            n2_vnum[i]     = {1'b0, c_vmag[i]};
        end
        n2_knum = {1'b0, c_usq} + {33'b0, r1_rho};
        n2_den  = {r1_rho[30:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_knum <= n2_knum;
            r2_den  <= n2_den;
            for (int i = 0; i < 3; i++) begin
                r2_vnum[i] <= n2_vnum[i];
            end
        end
    end

    // Dividers: three velocities and the kinetic energy term.
    logic [DIV_W-1:0] d_vquo [3];
    logic [2:0]       d_vnz;
    logic [DIV_W-1:0] d_kquo;
    logic             d_knz;

    for (genvar g = 0; g < 3; g++) begin : g_vdiv
        ecpc_div_pipe #(
            .N (DIV_W),
            .D (DEN_W)
        ) u_div (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_num    (r2_vnum[g]),
            .i_den    (r2_den),
            .o_quo    (d_vquo[g]),
            .o_rem_nz (d_vnz[g])
        );
    end

    ecpc_div_pipe #(
        .N (DIV_W),
        .D (DEN_W)
    ) u_kdiv (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r2_knum),
        .i_den    (r2_den),
        .o_quo    (d_kquo),
        .o_rem_nz (d_knz)
    );

    // Carry line alongside the dividers. Its second and third slots finish
    // the primitive-to-conserved energy: rho times |u|^2 in two halves.
    t_car  r_car  [DIV_W+1];
    t_car  n_car  [DIV_W+1];
    logic  r_cvld [DIV_W+1];
    logic [64:0]        c_low;
    logic [63:0]        c_ke0;
    t_sat               s_e0;

    always_comb begin
        n_car[0] = n_car0;
        for (int k = 1; k <= DIV_W; k++) begin
            n_car[k] = r_car[k-1];
        end
        n_car[1].pa = {32'b0, r_car[0].rho[30:0]} * {31'b0, r_car[0].usq[63:32]};
        n_car[1].pb = {32'b0, r_car[0].rho[30:0]} * {31'b0, r_car[0].usq[31:0]};
        c_low = 65'({r_car[1].pa[0], 32'b0}) + 65'(r_car[1].pb) + 65'(64'h1_0000_0000);
        c_ke0 = 64'(r_car[1].pa[62:1]) + 64'(c_low[64:33]);
        s_e0  = sat32($signed(r_car[1].ie) + $signed(c_ke0));
        n_car[2].e0   = s_e0.val;
        n_car[2].sat0 = r_car[1].sat0 | s_e0.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_W; k++) begin
                r_cvld[k] <= 1'b0;
            end
        end else if (en) begin
            r_cvld[0] <= r1_vld;
            for (int k = 1; k <= DIV_W; k++) begin
                r_cvld[k] <= r_cvld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= DIV_W; k++) begin
                r_car[k] <= n_car[k];
            end
        end
    end

    // Post stage 1: signed velocities and the internal energy difference.
    t_car               c_tail;
    t_post              n5_pst;
    t_sat               s_vel [3];
    logic [65:0]        c_qmag [3];
    logic [65:0]        c_qs   [3];
    logic signed [66:0] c_diff;
    logic [66:0]        c_dabs;

    logic               r5_vld;
    t_post              r5_pst;
    logic [63:0]        r5_mag;
    logic               r5_dneg;

    assign c_tail = r_car[DIV_W];

    always_comb begin
        n5_pst.act  = c_tail.act;
        n5_pst.bad  = c_tail.bad;
        n5_pst.rho  = c_tail.rho;
        n5_pst.mom  = c_tail.mom;
        n5_pst.e0   = c_tail.e0;
        n5_pst.sat0 = c_tail.sat0;
        n5_pst.vsat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            // Negative numerators round the quotient toward minus infinity.
            c_qmag[i] = {1'b0, d_vquo[i]} + 66'(d_vnz[i]);
            c_qs[i]   = c_tail.vneg[i] ? 66'(-c_qmag[i]) : {1'b0, d_vquo[i]};
            s_vel[i]  = sat32(c_qs[i][63:0]);
            n5_pst.vel[i] = s_vel[i].val;
            n5_pst.vsat   = n5_pst.vsat | s_vel[i].sat;
        end
        c_diff = 67'($signed(c_tail.e)) - $signed({2'b0, d_kquo});
        c_dabs = c_diff[66] ? 67'(-c_diff) : 67'(c_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r_cvld[DIV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_pst  <= n5_pst;
            r5_mag  <= c_dabs[63:0];
            r5_dneg <= c_diff[66];
        end
    end

    // Post stage 2: |E - ke| times gamma minus one, two partial products.
    logic        r6_vld;
    t_post       r6_pst;
    logic [62:0] r6_pp_hi;
    logic [62:0] r6_pp_lo;
    logic        r6_dneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_pst   <= r5_pst;
            r6_pp_hi <= {31'b0, r5_mag[63:32]} * {32'b0, r_gm1};
            r6_pp_lo <= {31'b0, r5_mag[31:0]} * {32'b0, r_gm1};
            r6_dneg  <= r5_dneg;
        end
    end

    // Post stage 3: assemble the product and flag a huge pressure.
    logic [94:0] c_prod;
    logic        r7_vld;
    t_post       r7_pst;
    logic [62:0] r7_prod;
    logic        r7_big;
    logic        r7_dneg;

    assign c_prod = {r6_pp_hi, 32'b0} + 95'(r6_pp_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_pst  <= r6_pst;
            r7_prod <= c_prod[62:0];
            r7_big  <= c_prod > {32'b0, 1'b1, 62'b0};
            r7_dneg <= r6_dneg;
        end
    end

    // Output stage: pressure rounding, result select and fault code.
    logic signed [63:0] c_ps;
    logic signed [63:0] c_p;
    t_sat               s_p;
    t_res               n_out;

    always_comb begin
        c_ps = r7_dneg ? -$signed(64'(r7_prod)) : $signed(64'(r7_prod));
        if (r7_big) begin
            c_p = r7_dneg ? -64'sd2147483649 : 64'sd2147483648;
        end else begin
            c_p = round16(c_ps);
        end
        s_p = sat32(c_p);

        n_out.density = r7_pst.rho;
        if (r7_pst.bad) begin
            n_out.x     = '0;
            n_out.y     = '0;
            n_out.z     = '0;
            n_out.eop   = '0;
            n_out.fault = FAULT_DENSITY;
        end else if (r7_pst.act == ACT_P2C) begin
            n_out.x     = r7_pst.mom[0];
            n_out.y     = r7_pst.mom[1];
            n_out.z     = r7_pst.mom[2];
            n_out.eop   = r7_pst.e0;
            n_out.fault = r7_pst.sat0 ? FAULT_SAT : FAULT_OK;
        end else begin
            n_out.x     = r7_pst.vel[0];
            n_out.y     = r7_pst.vel[1];
            n_out.z     = r7_pst.vel[2];
            n_out.eop   = s_p.val;
            n_out.fault = (r7_pst.vsat || s_p.sat) ? FAULT_SAT : FAULT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid                  = r_out_vld;
    assign o_out.out_density            = r_out.density;
    assign o_out.out_x                  = r_out.x;
    assign o_out.out_y                  = r_out.y;
    assign o_out.out_z                  = r_out.z;
    assign o_out.out_energy_or_pressure = r_out.eop;
    assign o_out.fault                  = r_out.fault;

endmodule

// ===== sv/ecpc_chk.sv =====
// Port-level checker for the Euler cell converter, bound to the top level.
`timescale 1ns / 1ps
`include "euler_conserved_primitive_convert_core_assert.svh"
module ecpc_chk import ecpc_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_out_density,
    input logic [W-1:0] i_out_x,
    input logic [W-1:0] i_out_y,
    input logic [W-1:0] i_out_z,
    input logic [W-1:0] i_out_eop,
    input logic [1:0]   i_fault
);

    // Only the three defined fault codes ever leave the block.
    `ECPC_ASSERT_NOW(a_fault_code, i_clk, i_rst_n, i_out_valid, (i_fault == FAULT_OK) || (i_fault == FAULT_DENSITY) || (i_fault == FAULT_SAT), "undefined fault code")

    // A density fault goes with a non-positive density, and only then.
    `ECPC_ASSERT_NOW(a_density_fault, i_clk, i_rst_n, i_out_valid, (i_fault == FAULT_DENSITY) == ($signed(i_out_density) <= 0), "density fault mismatch")

    // A density fault zeroes every converted field.
    `ECPC_ASSERT_NOW(a_fault_zero, i_clk, i_rst_n, i_out_valid && (i_fault == FAULT_DENSITY), (i_out_x == '0) && (i_out_y == '0) && (i_out_z == '0) && (i_out_eop == '0), "faulted cell not zeroed")

    // A stalled output beat holds.
    `ECPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_x) && $stable(i_out_eop) && $stable(i_fault), "stalled beat changed")

endmodule

bind euler_conserved_primitive_convert_core ecpc_chk u_ecpc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_density (o_out.out_density),
    .i_out_x       (o_out.out_x),
    .i_out_y       (o_out.out_y),
    .i_out_z       (o_out.out_z),
    .i_out_eop     (o_out.out_energy_or_pressure),
    .i_fault       (o_out.fault)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the Euler cell converter: directed and random cells.
`timescale 1ns / 1ps
module testbench;
    import ecpc_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic                action;
        logic signed [W-1:0] rho;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic signed [W-1:0] ep;
    } cell_t;

    typedef struct {
        logic [W-1:0] rho;
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] z;
        logic [W-1:0] ep;
        logic [1:0]   fault;
    } conv_t;

    typedef struct {
        cell_t stim;
        bit    typed;
        conv_t conv;
    } stim_row_t;

    localparam int LATENCY    = 70;
    localparam int STALL_CAP  = 4000;
    localparam int PHASE_ITEMS = 250;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    ecpc_in_if  cell_in ();
    ecpc_out_if cell_out ();

    euler_conserved_primitive_convert_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (cell_in.sink),
        .o_out      (cell_out.source)
    );

    // Mirror of the gamma registers, updated together with each write.
    logic [CFG_W-1:0] gm1_q;
    logic [CFG_W-1:0] igm1_q;

    conv_t pending_q[$];
    bit    failed;
    bit    cur_typed;
    conv_t cur_conv;
    int    cycle_cnt;
    int    quiet_cnt;
    int    stall_left;
    bit    calm;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Round half up of x / 2^k.
    function automatic wide_t round_down(input wide_t x, input int k);
        wide_t t;
        t = x + (wide_t'(1) <<< (k - 1));
        return t >>> k;
    endfunction

    // Division rounded toward minus infinity; the divisor is positive here.
    function automatic wide_t floor_div(input wide_t num, input wide_t den);
        wide_t q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    // Clamp to signed 32 bits, noting any clamp.
    function automatic logic [W-1:0] clamp32(input wide_t v, inout bit sat);
        if (v > wide_t'(32'sh7fff_ffff)) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -wide_t'(64'sh8000_0000)) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[W-1:0];
    endfunction

    // Expected converted cell under the current gamma settings.
    function automatic conv_t convert_cell(input cell_t c);
        conv_t r;
        wide_t rho, e, sq, ke, ie, diff, mag, gm, igm, p, den;
        wide_t comp[3];
        logic [W-1:0] res[3];
        bit sat;
        rho = c.rho;
        e   = c.ep;
        comp[0] = c.x;
        comp[1] = c.y;
        comp[2] = c.z;
        gm  = wide_t'(gm1_q);
        igm = wide_t'(igm1_q);
        sat = 1'b0;
        sq  = 0;
        r.rho = c.rho;
        if (rho <= 0) begin
            r.x = '0;
            r.y = '0;
            r.z = '0;
            r.ep = '0;
            r.fault = FAULT_DENSITY;
            return r;
        end
        for (int i = 0; i < 3; i++) sq = sq + comp[i] * comp[i];
        if (c.action == ACT_P2C) begin
            for (int i = 0; i < 3; i++) res[i] = clamp32(round_down(rho * comp[i], 16), sat);
            ke = (rho * sq + (wide_t'(1) <<< 32)) >>> 33;
            ie = round_down(e * igm, 16);
            r.ep = clamp32(ie + ke, sat);
        end else begin
            den = 2 * rho;
            for (int i = 0; i < 3; i++)
                res[i] = clamp32(floor_div(comp[i] * 131072 + rho, den), sat);
            ke   = (sq + rho) / den;
            diff = e - ke;
            mag  = diff < 0 ? -diff : diff;
            if (gm != 0 && mag > (wide_t'(1) <<< 62) / gm)
                p = diff < 0 ? -(wide_t'(1) <<< 31) - 1 : (wide_t'(1) <<< 31);
            else
                p = round_down(diff < 0 ? -(mag * gm) : mag * gm, 16);
            r.ep = clamp32(p, sat);
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        r.fault = sat ? FAULT_SAT : FAULT_OK;
        return r;
    endfunction

    // A Q16.16 word spread over many magnitudes.
    function automatic logic signed [W-1:0] pick_word();
        logic signed [W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            2: v = 0;
            default: begin
                v = $urandom >> $urandom_range(1, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    // A random cell, mostly with a positive density.
    function automatic cell_t pick_cell();
        cell_t c;
        c.action = $urandom_range(0, 1) ? ACT_C2P : ACT_P2C;
        if ($urandom_range(0, 99) < 6) begin
            case ($urandom_range(0, 2))
                0: c.rho = 0;
                1: c.rho = 32'sh8000_0000;
                default: c.rho = 32'sh8000_0000 | $urandom;
            endcase
        end else begin
            c.rho = ($urandom & 32'h7fff_ffff) >> $urandom_range(0, 30);
            if (c.rho <= 0) c.rho = 1;
        end
        c.x  = pick_word();
        c.y  = pick_word();
        c.z  = pick_word();
        c.ep = pick_word();
        return c;
    endfunction

    // Input beat accepted: queue its expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && cell_in.valid && cell_in.ready) begin
            cell_t c;
            c.action = cell_in.action;
            c.rho = cell_in.in_density;
            c.x   = cell_in.in_x;
            c.y   = cell_in.in_y;
            c.z   = cell_in.in_z;
            c.ep  = cell_in.in_energy_or_pressure;
            pending_q.push_back(cur_typed ? cur_conv : convert_cell(c));
        end
    end

    // Output beat accepted: compare with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && cell_out.valid && cell_out.ready) begin
            conv_t want;
            if (pending_q.size() == 0) begin
                $error("output beat with no expected result");
                failed = 1'b1;
            end else begin
                want = pending_q.pop_front();
                if (cell_out.out_density !== want.rho) begin
                    $error("out_density: expected %h, got %h", want.rho, cell_out.out_density);
                    failed = 1'b1;
                end
                if (cell_out.out_x !== want.x) begin
                    $error("out_x: expected %h, got %h", want.x, cell_out.out_x);
                    failed = 1'b1;
                end
                if (cell_out.out_y !== want.y) begin
                    $error("out_y: expected %h, got %h", want.y, cell_out.out_y);
                    failed = 1'b1;
                end
                if (cell_out.out_z !== want.z) begin
                    $error("out_z: expected %h, got %h", want.z, cell_out.out_z);
                    failed = 1'b1;
                end
                if (cell_out.out_energy_or_pressure !== want.ep) begin
                    $error("out_energy_or_pressure: expected %h, got %h", want.ep,
                           cell_out.out_energy_or_pressure);
                    failed = 1'b1;
                end
                if (cell_out.fault !== want.fault) begin
                    $error("fault: expected %0d, got %0d", want.fault, cell_out.fault);
                    failed = 1'b1;
                end
            end
        end
    end

    // Output back-pressure: calm stretches, short stalls and a few long ones.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        calm <= (cycle_cnt % 1024) < 200;
        if (!i_rst_n) begin
            cell_out.ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            cell_out.ready <= 1'b0;
        end else if (calm) begin
            cell_out.ready <= 1'b1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                stall_left <= $urandom_range(10, 60);
                cell_out.ready <= 1'b0;
            end else begin
                cell_out.ready <= (r < 75);
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge i_clk) begin
        if ((cell_in.valid && cell_in.ready) || (cell_out.valid && cell_out.ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_CAP) begin
            $display("** euler_conserved_primitive_convert_core: FAILED **");
            $finish;
        end
    end

    // Present one cell, after an optional gap, and hold it until accepted.
    task automatic send_cell(input cell_t c, input bit typed, input conv_t want);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (calm || r < 60) ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (gap > 0) begin
            cell_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_in.valid <= 1'b1;
        cell_in.action <= c.action;
        cell_in.in_density <= c.rho;
        cell_in.in_x <= c.x;
        cell_in.in_y <= c.y;
        cell_in.in_z <= c.z;
        cell_in.in_energy_or_pressure <= c.ep;
        cur_typed <= typed;
        cur_conv <= want;
        do @(posedge i_clk); while (!cell_in.ready);
    endtask

    // Drop valid and wait until every expected beat has come out.
    task automatic drain();
        cell_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Write one gamma register; the block is idle here.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_GM1) gm1_q = val;
        else igm1_q = val;
    endtask

    task automatic random_cells(input int n);
        conv_t none;
        none = '{default: '0};
        repeat (n) send_cell(pick_cell(), 1'b0, none);
    endtask

    // Directed cells: extremes, both actions, nonpositive density, simple values.
    function automatic stim_row_t row(input logic a, input int rho, input int x, input int y,
                                      input int z, input int ep, input bit typed,
                                      input int ox, input int oy, input int oz,
                                      input int oep, input logic [1:0] f);
        stim_row_t s;
        s.stim = '{a, rho, x, y, z, ep};
        s.typed = typed;
        s.conv = '{rho, ox, oy, oz, oep, f};
        return s;
    endfunction

    stim_row_t dir_rows[$];

    initial begin
        int mx;
        int mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        failed = 1'b0;
        cycle_cnt = 0;
        quiet_cnt = 0;
        calm = 1'b0;
        cur_typed = 1'b0;
        gm1_q = GM1_RST;
        igm1_q = IGM1_RST;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_GM1;
        i_cfg_data <= '0;
        cell_in.valid <= 1'b0;
        cell_in.action <= ACT_P2C;
        cell_in.in_density <= '0;
        cell_in.in_x <= '0;
        cell_in.in_y <= '0;
        cell_in.in_z <= '0;
        cell_in.in_energy_or_pressure <= '0;

        dir_rows.push_back(row(ACT_P2C, 65536, 0, 0, 0, 0, 1, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_P2C, 65536, 65536, 0, 0, 65536, 1,
                               65536, 0, 0, 196608, FAULT_OK));
        dir_rows.push_back(row(ACT_C2P, 65536, 65536, 0, 0, 196608, 1,
                               65536, 0, 0, 65535, FAULT_OK));
        dir_rows.push_back(row(ACT_P2C, 0, mx, mn, 5, 7, 1, 0, 0, 0, 0, FAULT_DENSITY));
        dir_rows.push_back(row(ACT_C2P, mn, 1, 2, 3, 4, 1, 0, 0, 0, 0, FAULT_DENSITY));
        dir_rows.push_back(row(ACT_C2P, -1, mx, mx, mx, mx, 1, 0, 0, 0, 0, FAULT_DENSITY));
        dir_rows.push_back(row(ACT_P2C, mn, 0, 0, 0, 0, 1, 0, 0, 0, 0, FAULT_DENSITY));
        dir_rows.push_back(row(ACT_P2C, mx, mx, mx, mx, mx, 0, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_P2C, mx, mn, mn, mn, mn, 0, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_P2C, 1, mn, mx, -1, mn, 0, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_C2P, 1, mx, mx, mx, mx, 0, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_C2P, 1, mn, mn, mn, mn, 0, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_C2P, mx, 0, 0, 0, mx, 0, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_C2P, mx, mn, mx, 0, mn, 0, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_C2P, 131072, -1, 1, -65536, -65536, 0,
                               0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_C2P, 3, 1, -1, 2, 0, 0, 0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_P2C, 98304, -32768, 32768, 1, -1, 0,
                               0, 0, 0, 0, FAULT_OK));
        dir_rows.push_back(row(ACT_C2P, 65536, 0, 0, 0, mn, 0, 0, 0, 0, 0, FAULT_OK));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: directed table, then random cells.
        foreach (dir_rows[i]) send_cell(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].conv);
        random_cells(PHASE_ITEMS);

        // Further settings: smallest, largest, zero, a monatomic gas, random.
        drain();
        write_reg(CFG_GM1, 31'd1);
        write_reg(CFG_IGM1, 31'd1);
        random_cells(PHASE_ITEMS);
        drain();
        write_reg(CFG_GM1, 31'h7fff_ffff);
        write_reg(CFG_IGM1, 31'h7fff_ffff);
        random_cells(PHASE_ITEMS);
        drain();
        write_reg(CFG_GM1, 31'd0);
        write_reg(CFG_IGM1, 31'd0);
        random_cells(PHASE_ITEMS);
        drain();
        write_reg(CFG_GM1, 31'd43691);
        write_reg(CFG_IGM1, 31'd98304);
        random_cells(PHASE_ITEMS);
        drain();
        write_reg(CFG_GM1, CFG_W'($urandom));
        write_reg(CFG_IGM1, CFG_W'($urandom >> $urandom_range(0, 20)));
        random_cells(PHASE_ITEMS);

        drain();
        repeat (LATENCY + 30) @(posedge i_clk);
        if (!failed)
            $display("** euler_conserved_primitive_convert_core: PASSED **");
        else
            $display("** euler_conserved_primitive_convert_core: FAILED **");
        $finish;
    end

endmodule
